@@ hdl/ppm_pkg.sv @@
// Shared widths, register map and constants of the pedal plausibility monitor.
package ppm_pkg;

  // Fraction format: signed Q2.14.
  localparam int Q_W      = 16;
  localparam int Q_FRAC   = 14;
  localparam int Q_ONE    = 16384;

  // Fixed field widths.
  localparam int DAC_W    = 12;
  localparam int MS_W     = 10;
  localparam int LIMIT_W  = 16;

  // Configuration port.
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 5;

  // Thresholds in Q2.14: accelerator above 25 percent.
  localparam int ACCEL_ON_TH = 4096;

  // Register reset values.
  localparam int RST_ACCEL_MIN = 459;
  localparam int RST_ACCEL_MAX = 4095;
  localparam int RST_BRAKE_MIN = 906;
  localparam int RST_BRAKE_MAX = 3636;
  localparam int RST_LIMIT     = 100;

  typedef enum logic [2:0] {
    REG_ACCEL_A_MIN = 3'd0,
    REG_ACCEL_A_MAX = 3'd1,
    REG_ACCEL_B_MIN = 3'd2,
    REG_ACCEL_B_MAX = 3'd3,
    REG_BRAKE_MIN   = 3'd4,
    REG_BRAKE_MAX   = 3'd5,
    REG_FAULT_LIMIT = 3'd6
  } cfg_reg_t;

endpackage

@@ hdl/ppm_if.sv @@
// Valid/ready channel interfaces for sensor samples and drive results.
interface ppm_in_if #(
  parameter int ADC_BITS = 12
);
  logic                          valid;
  logic                          ready;
  logic [ADC_BITS-1:0]           accel_a_code;
  logic [ADC_BITS-1:0]           accel_b_code;
  logic [ADC_BITS-1:0]           brake_code;
  logic [ppm_pkg::MS_W-1:0]      ms_elapsed;

  modport source (output valid, accel_a_code, accel_b_code, brake_code, ms_elapsed,
                  input ready);
  modport sink (input valid, accel_a_code, accel_b_code, brake_code, ms_elapsed,
                output ready);
endinterface

interface ppm_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppm_pkg::DAC_W-1:0]     drive_code;
  logic                          in_fault_mode;
  logic                          sensor_fault_now;
  logic                          brake_latch_set;

  modport source (output valid, drive_code, in_fault_mode, sensor_fault_now,
                  brake_latch_set, input ready);
  modport sink (input valid, drive_code, in_fault_mode, sensor_fault_now,
                brake_latch_set, output ready);
endinterface

@@ hdl/ppm_div.sv @@
// Serial restoring divider that normalizes one ADC code to a saturated Q2.14 fraction.
module ppm_div #(
  parameter int ADC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ADC_BITS-1:0]              code,
  input  logic [ADC_BITS-1:0]              lo,
  input  logic [ADC_BITS-1:0]              hi,
  output logic                             done,
  output logic signed [ppm_pkg::Q_W-1:0]   quot
);

  localparam int QW = ppm_pkg::Q_W;
  localparam int CW = $clog2(QW);
  localparam logic [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic [CW-1:0] LAST = CW'(QW-1);

  logic signed [ADC_BITS:0]   diff_s;
  logic signed [ADC_BITS:0]   span_s;
  logic [ADC_BITS:0]          neg_diff;
  logic [ADC_BITS-1:0]        mag;
  logic                       span_ok;
  logic                       ovf;
  logic [ADC_BITS+1:0]        trial;
  logic                       take;
  logic [QW-1:0]              q_fin;
  logic [QW-1:0]              sat_val;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0]        rem_r, rem_nxt;
  logic [QW-1:0]              num_r, num_nxt;
  logic [QW-1:0]              q_r, q_nxt;
  logic                       neg_r, neg_nxt;
  logic [ADC_BITS-1:0]        sp_r, sp_nxt;
  logic [QW-1:0]              res_r, res_nxt;

  assign diff_s   = $signed({1'b0, code}) - $signed({1'b0, lo});
  assign span_s   = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign neg_diff = -diff_s;
  assign mag      = diff_s[ADC_BITS] ? neg_diff[ADC_BITS-1:0] : diff_s[ADC_BITS-1:0];
  assign span_ok  = !span_s[ADC_BITS] && (span_s != '0);
  // Quotient would need more than QW bits; it saturates either way.
  assign ovf      = {2'b00, mag} >= {span_s[ADC_BITS-1:0], 2'b00};

  assign trial = {1'b0, rem_r, num_r[QW-1]} - {2'b00, sp_r};
  assign take  = !trial[ADC_BITS+1];
  assign q_fin = {q_r[QW-2:0], take};

  always_comb begin
    if (!neg_r) begin
      sat_val = q_fin[QW-1] ? QMAX : q_fin;
    end else begin
      sat_val = (q_fin > QMIN) ? QMIN : (-q_fin);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    sp_nxt   = sp_r;
    res_nxt  = res_r;
    if (start) begin
      if (!span_ok) begin
        res_nxt  = '0;
        done_nxt = 1'b1;
      end else if (ovf) begin
        res_nxt  = diff_s[ADC_BITS] ? QMIN : QMAX;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        // The top quotient bits are known zero, so the high part of the
        // shifted dividend seeds the remainder directly.
        rem_nxt  = {2'b00, mag[ADC_BITS-1:2]};
        num_nxt  = {mag[1:0], {(QW-2){1'b0}}};
        q_nxt    = '0;
        neg_nxt  = diff_s[ADC_BITS];
        sp_nxt   = span_s[ADC_BITS-1:0];
      end
    end else if (busy_r) begin
      rem_nxt = take ? trial[ADC_BITS-1:0] : {rem_r[ADC_BITS-2:0], num_r[QW-1]};
      num_nxt = {num_r[QW-2:0], 1'b0};
      q_nxt   = q_fin;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    sp_r  <= sp_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign quot = $signed(res_r);

endmodule

@@ hdl/pedal_plausibility_monitor_unit.sv @@
// Top level of the pedal plausibility monitor: sequencer, checks, timer and registers.
//
//  Channel   Direction  Handshake              Carries
//  in_ch     sink       valid/ready            accel_a_code, accel_b_code, brake_code,
//                                              ms_elapsed
//  out_ch    source     valid/ready            drive_code, in_fault_mode,
//                                              sensor_fault_now, brake_latch_set
//  APB       slave      psel/penable, pready=1 seven configuration registers at 4*i
//
// One item is taken at a time. Its three sensor codes are normalized one after
// another on a single serial divider that produces one quotient bit per cycle,
// and the item then passes through an evaluation step before the next ready.
// A sensor with an empty span or a saturating quotient skips the bit-serial
// loop and finishes early.
// Reset is synchronous and active low; it restores the register reset values
// and clears fault mode, the brake latch and the fault timer.
// The result sits in an output register. If it has not been taken when the
// next item finishes, the evaluation cycle waits until the output is free.
module pedal_plausibility_monitor_unit #(
  parameter int ADC_BITS   = 12,
  parameter int TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ppm_in_if.sink                        in_ch,
  ppm_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppm_pkg::CFG_AW-1:0]    paddr,
  input  logic [ppm_pkg::CFG_DW-1:0]    pwdata,
  output logic [ppm_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int QW     = ppm_pkg::Q_W;
  localparam int DW     = ppm_pkg::DAC_W;
  localparam int LW     = ppm_pkg::LIMIT_W;
  localparam int MSW    = ppm_pkg::MS_W;
  // Products of a fraction by small constants (up to 20) fit in QW+5 bits.
  localparam int MW     = QW + 5;
  // Timer sum and limit compare widths.
  localparam int SUMW   = ((TIMER_BITS > MSW) ? TIMER_BITS : MSW) + 1;
  localparam int CMPW   = (TIMER_BITS > LW) ? TIMER_BITS : LW;
  localparam int PRODW  = ppm_pkg::Q_FRAC + DW;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_DIV_START = 4'b0010,
    ST_DIV_WAIT  = 4'b0100,
    ST_EVAL      = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    SEL_ACCEL_A = 2'd0,
    SEL_ACCEL_B = 2'd1,
    SEL_BRAKE   = 2'd2
  } sensor_sel_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands at the access phase; pready never
  // stalls. Addresses beyond the last register are ignored on write and read
  // back as zero.
  // ---------------------------------------------------------------------------
  logic [ADC_BITS-1:0]  a_min_r, a_max_r, b_min_r, b_max_r, r_min_r, r_max_r;
  logic [LW-1:0]        limit_r;
  logic                 cfg_wr;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_min_r <= ADC_BITS'(ppm_pkg::RST_ACCEL_MIN);
      a_max_r <= ADC_BITS'(ppm_pkg::RST_ACCEL_MAX);
      b_min_r <= ADC_BITS'(ppm_pkg::RST_ACCEL_MIN);
      b_max_r <= ADC_BITS'(ppm_pkg::RST_ACCEL_MAX);
      r_min_r <= ADC_BITS'(ppm_pkg::RST_BRAKE_MIN);
      r_max_r <= ADC_BITS'(ppm_pkg::RST_BRAKE_MAX);
      limit_r <= LW'(ppm_pkg::RST_LIMIT);
    end else if (cfg_wr) begin
      case (reg_idx)
        ppm_pkg::REG_ACCEL_A_MIN: a_min_r <= pwdata[ADC_BITS-1:0];
        ppm_pkg::REG_ACCEL_A_MAX: a_max_r <= pwdata[ADC_BITS-1:0];
        ppm_pkg::REG_ACCEL_B_MIN: b_min_r <= pwdata[ADC_BITS-1:0];
        ppm_pkg::REG_ACCEL_B_MAX: b_max_r <= pwdata[ADC_BITS-1:0];
        ppm_pkg::REG_BRAKE_MIN:   r_min_r <= pwdata[ADC_BITS-1:0];
        ppm_pkg::REG_BRAKE_MAX:   r_max_r <= pwdata[ADC_BITS-1:0];
        ppm_pkg::REG_FAULT_LIMIT: limit_r <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ppm_pkg::REG_ACCEL_A_MIN: prdata = ppm_pkg::CFG_DW'(a_min_r);
      ppm_pkg::REG_ACCEL_A_MAX: prdata = ppm_pkg::CFG_DW'(a_max_r);
      ppm_pkg::REG_ACCEL_B_MIN: prdata = ppm_pkg::CFG_DW'(b_min_r);
      ppm_pkg::REG_ACCEL_B_MAX: prdata = ppm_pkg::CFG_DW'(b_max_r);
      ppm_pkg::REG_BRAKE_MIN:   prdata = ppm_pkg::CFG_DW'(r_min_r);
      ppm_pkg::REG_BRAKE_MAX:   prdata = ppm_pkg::CFG_DW'(r_max_r);
      ppm_pkg::REG_FAULT_LIMIT: prdata = ppm_pkg::CFG_DW'(limit_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. The sample is captured on acceptance, then each sensor is sent
  // through the shared divider in turn, then the evaluation state evaluates all checks.
  // ---------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  sensor_sel_t          sel_r, sel_nxt;
  logic [ADC_BITS-1:0]  ca_r, cb_r, cr_r;
  logic [MSW-1:0]       ms_r;
  logic signed [QW-1:0] a_r, b_r, r_r;

  logic                 in_acc;
  logic                 eval_go;
  logic                 div_start;
  logic                 div_done;
  logic signed [QW-1:0] div_quot;
  logic [ADC_BITS-1:0]  div_code, div_lo, div_hi;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign div_start   = (state_r == ST_DIV_START);
  // Evaluation commits only when the output register is free or being drained.
  assign eval_go     = (state_r == ST_EVAL) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    unique case (sel_r)
      SEL_ACCEL_A: begin
        div_code = ca_r;
        div_lo   = a_min_r;
        div_hi   = a_max_r;
      end
      SEL_ACCEL_B: begin
        div_code = cb_r;
        div_lo   = b_min_r;
        div_hi   = b_max_r;
      end
      SEL_BRAKE: begin
        div_code = cr_r;
        div_lo   = r_min_r;
        div_hi   = r_max_r;
      end
      default: begin
        div_code = ca_r;
        div_lo   = a_min_r;
        div_hi   = a_max_r;
      end
    endcase
  end

  ppm_div #(
    .ADC_BITS (ADC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .code  (div_code),
    .lo    (div_lo),
    .hi    (div_hi),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DIV_START;
          sel_nxt   = SEL_ACCEL_A;
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          priority case (sel_r)
            SEL_ACCEL_A: begin
              sel_nxt   = SEL_ACCEL_B;
              state_nxt = ST_DIV_START;
            end
            SEL_ACCEL_B: begin
              sel_nxt   = SEL_BRAKE;
              state_nxt = ST_DIV_START;
            end
            default: begin
              state_nxt = ST_EVAL;
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_ACCEL_A;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Sample capture and fraction storage.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ca_r <= in_ch.accel_a_code;
      cb_r <= in_ch.accel_b_code;
      cr_r <= in_ch.brake_code;
      ms_r <= in_ch.ms_elapsed;
    end
    if ((state_r == ST_DIV_WAIT) && div_done) begin
      if (sel_r == SEL_ACCEL_A) begin
        a_r <= div_quot;
      end
      if (sel_r == SEL_ACCEL_B) begin
        b_r <= div_quot;
      end
      if (sel_r == SEL_BRAKE) begin
        r_r <= div_quot;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluation. Constant multiples of the fractions are built from shifts and
  // adds; all of it is combinational and settles within the evaluation state.
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] a_x, b_x, r_x;
  logic signed [MW-1:0] a10, a20, b11, b9, r10;
  logic signed [MW-1:0] q_one_x;
  logic                 disagree;
  logic                 range_fault;
  logic                 fault_now;

  assign a_x     = MW'(a_r);
  assign b_x     = MW'(b_r);
  assign r_x     = MW'(r_r);
  assign a10     = (a_x <<< 3) + (a_x <<< 1);
  assign a20     = a10 <<< 1;
  assign b11     = (b_x <<< 3) + (b_x <<< 1) + b_x;
  assign b9      = (b_x <<< 3) + b_x;
  assign r10     = (r_x <<< 3) + (r_x <<< 1);
  assign q_one_x = MW'(ppm_pkg::Q_ONE);

  // The two accelerator fractions must agree within 10 percent of each other.
  assign disagree    = (a10 > b11) || (a10 < b9);
  assign range_fault = (ca_r > a_max_r) || (ca_r < a_min_r)
                    || (cb_r > b_max_r) || (cb_r < b_min_r)
                    || (cr_r > r_max_r) || (cr_r < r_min_r);
  assign fault_now   = disagree || range_fault;

  // Fault persistence timer. The first faulty sample only starts the timer;
  // later faulty samples add their elapsed time, saturating at all ones.
  localparam logic [SUMW-1:0] TMAX = SUMW'({TIMER_BITS{1'b1}});

  logic                   fault_mode_r, fault_mode_nxt;
  logic                   latch_r, latch_nxt;
  logic                   timer_run_r, timer_run_nxt;
  logic [TIMER_BITS-1:0]  timer_r, timer_nxt;
  logic [SUMW-1:0]        timer_sum;
  logic [TIMER_BITS-1:0]  timer_acc;

  assign timer_sum = SUMW'(timer_r) + SUMW'(ms_r);
  assign timer_acc = timer_run_r ? ((timer_sum > TMAX) ? {TIMER_BITS{1'b1}}
                                                       : timer_sum[TIMER_BITS-1:0])
                                 : '0;

  always_comb begin
    fault_mode_nxt = fault_mode_r;
    timer_run_nxt  = timer_run_r;
    timer_nxt      = timer_r;
    latch_nxt      = latch_r;
    if (eval_go) begin
      if (fault_now) begin
        if (CMPW'(timer_acc) > CMPW'(limit_r)) begin
          fault_mode_nxt = 1'b1;
          timer_run_nxt  = 1'b0;
          timer_nxt      = '0;
        end else begin
          timer_run_nxt  = 1'b1;
          timer_nxt      = timer_acc;
        end
      end else begin
        fault_mode_nxt = 1'b0;
        timer_run_nxt  = 1'b0;
        timer_nxt      = '0;
      end
      // Brake plausibility: set on heavy throttle with the brake applied,
      // released only once the throttle drops below 5 percent.
      if (!latch_r && (a_r > QW'(ppm_pkg::ACCEL_ON_TH)) && (r10 > q_one_x)) begin
        latch_nxt = 1'b1;
      end else if (latch_r && (a20 < q_one_x)) begin
        latch_nxt = 1'b0;
      end
    end
  end

  // Drive code: round(a * 4095 / 2^14), clamped to the DAC range; zero in fault mode or with the latch set.
  logic [ppm_pkg::Q_FRAC-1:0] a_frac;
  logic [PRODW-1:0]           a_scaled;
  logic [DW-1:0]              drive_val;

  assign a_frac   = a_r[ppm_pkg::Q_FRAC-1:0];
  assign a_scaled = {a_frac, {DW{1'b0}}} - PRODW'(a_frac)
                  + PRODW'(1 << (ppm_pkg::Q_FRAC - 1));

  always_comb begin
    if (fault_mode_nxt || latch_nxt) begin
      drive_val = '0;
    end else if (a_r >= QW'(ppm_pkg::Q_ONE)) begin
      drive_val = {DW{1'b1}};
    end else if (a_r > 0) begin
      drive_val = a_scaled[PRODW-1:ppm_pkg::Q_FRAC];
    end else begin
      drive_val = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Fault mode and the latch only change at evaluation, which
  // waits for the output to be free, so their registers feed the port directly.
  // ---------------------------------------------------------------------------
  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  drive_r;
  logic           fault_now_r;

  always_comb begin
    if (eval_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      fault_mode_r <= 1'b0;
      latch_r      <= 1'b0;
      timer_run_r  <= 1'b0;
      timer_r      <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      fault_mode_r <= fault_mode_nxt;
      latch_r      <= latch_nxt;
      timer_run_r  <= timer_run_nxt;
      timer_r      <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go) begin
      drive_r     <= drive_val;
      fault_now_r <= fault_now;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.drive_code       = drive_r;
  assign out_ch.in_fault_mode    = fault_mode_r;
  assign out_ch.sensor_fault_now = fault_now_r;
  assign out_ch.brake_latch_set  = latch_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An accepted item always starts with accelerator sensor one.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV_START) && (sel_r == SEL_ACCEL_A))
    else $error("accepted item did not start the divider on sensor one");

  // The divider only finishes while the sequencer is waiting for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // A stopped timer always holds zero.
  a_timer_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !timer_run_r |-> (timer_r == '0))
    else $error("fault timer nonzero while stopped");

  // A result is never overwritten while it waits to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !eval_go)
    else $error("evaluation committed over a pending result");

endmodule
